// ===== rtl/sdp_pkg.sv =====
// Package: shared types, codes and constants of the status datagram parser.
`default_nettype none
package sdp_pkg;

   // Number of operator and encoder slots
   localparam int unsigned NUM_SLOTS = 4;

   // Header and capsule constants
   localparam logic [7:0]  HDR_LEN      = 8'd8;
   localparam logic [7:0]  HDR_VERSION  = 8'd1;
   localparam logic [15:0] STATUS_MAGIC = 16'h4553;
   localparam logic [15:0] OPER_MAGIC   = 16'h5053;
   localparam logic [7:0]  OPER_LEN     = 8'd12;
   localparam logic [7:0]  ENC_LEN      = 8'd4;

   // Result queue depth
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_CAPHDR  = 3'd1,
      PH_OPER    = 3'd2,
      PH_ENC     = 3'd3,
      PH_DISCARD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OPER = 2'd0,
      KIND_ENC  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_LENGTH  = 3'd1,
      ST_VERSION = 3'd2,
      ST_MAGIC   = 3'd3,
      ST_SHORT   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         slot;
      logic signed [15:0] position;
      logic [15:0]        aux_word;
      logic [2:0]         status;
      logic [7:0]         peer_seq;
      logic [7:0]         echo_byte;
      logic [31:0]        clock_ms;
      logic               run_end;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/status_datagram_parser.sv =====
// Top level: byte-serial status datagram parser with a small result queue.
//
// Usage:
//   req channel carries one datagram byte per beat (data_byte, final_byte
//   marks the last byte). rsp channel carries result beats: operator update,
//   encoder update, or the datagram summary (kind done) after the final byte.
//   Each accepted byte updates the parser state in the same cycle; its
//   results are written to a four-entry result queue and appear on rsp in
//   the order written. A byte accepts every cycle as long as
//   the queue holds at most two results, so the throughput is one byte per
//   cycle; a byte that closes a capsule and the datagram at once gives two
//   results, which leave the queue in two consecutive rsp beats.
//   req_stall rises while more than two results wait, i.e. when the receiver
//   on rsp stalls long enough to back the queue up.
//   run_end marks the last result caused by one byte.
//   Reset (synchronous, active high) empties the queue and returns the
//   parser to the start of a header with all stored values cleared.
`default_nettype none
module status_datagram_parser
   import sdp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   // Parser state
   phase_type  phase_ff,  phase_in;
   logic [3:0] off_ff,    off_in;
   logic [7:0] len_ff,    len_in;
   logic [7:0] slot_ff,   slot_in;
   logic [31:0] acc_ff,   acc_in;
   logic [15:0] pos_ff,   pos_in;
   logic [7:0] echo_ff,   echo_in;
   status_type err_ff,    err_in;
   logic [7:0] seq_ff,    seq_in;
   logic [31:0] clk_ff,   clk_in;

   // Result queue
   rsp_type              q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff,    cnt_in;

   logic       accept;
   logic       pop;
   logic [7:0] b;
   logic       last;
   logic [15:0] magic;
   logic [31:0] acc_shift;
   logic       slot_ok;
   logic       upd_valid;
   kind_type   upd_kind;
   status_type sum_status;
   rsp_type    upd_rsp;
   rsp_type    sum_rsp;
   rsp_type    res0;
   logic       push0;
   logic       push1;

   // Handshakes: stall input while fewer than two queue entries are free
   assign req_stall   = (cnt_ff > RSP_CNT_W'(RSP_DEPTH - 2));
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = (cnt_ff != '0);
   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_payload = q_ff[rd_ptr_ff];

   assign b         = req_payload.data_byte;
   assign last      = req_payload.final_byte;
   assign magic     = {acc_ff[7:0], b};
   assign acc_shift = {acc_ff[23:0], b};
   assign slot_ok   = ({1'b0, slot_ff} < 9'(NUM_SLOTS));

   // Parse one byte and form its results
   always_comb begin
      phase_in   = phase_ff;
      off_in     = off_ff;
      len_in     = len_ff;
      slot_in    = slot_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      echo_in    = echo_ff;
      err_in     = err_ff;
      seq_in     = seq_ff;
      clk_in     = clk_ff;
      upd_valid  = 1'b0;
      upd_kind   = KIND_OPER;
      sum_status = ST_OK;
      sum_rsp    = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               unique case (off_ff)
                  4'd0: begin
                     if (b != HDR_LEN) begin
                        err_in = ST_LENGTH; phase_in = PH_DISCARD; off_in = '0;
                     end else begin
                        off_in = 4'd1;
                     end
                  end
                  4'd1: begin
                     if (b != HDR_VERSION) begin
                        err_in = ST_VERSION; phase_in = PH_DISCARD; off_in = '0;
                     end else begin
                        off_in = 4'd2;
                     end
                  end
                  4'd2: begin
                     acc_in = {24'd0, b};
                     off_in = 4'd3;
                  end
                  4'd3: begin
                     if (magic != STATUS_MAGIC) begin
                        err_in = ST_MAGIC; phase_in = PH_DISCARD; off_in = '0;
                     end else begin
                        off_in = 4'd4;
                     end
                  end
                  4'd4: begin
                     seq_in = b;
                     off_in = 4'd5;
                  end
                  4'd5: begin
                     echo_in = b;
                     off_in  = 4'd6;
                  end
                  4'd6, 4'd7: off_in = off_ff + 4'd1;
                  default: begin
                     // Clock bytes: latch the word on the last one
                     acc_in = acc_shift;
                     if (off_ff >= 4'd11) begin
                        clk_in   = acc_shift;
                        phase_in = PH_CAPHDR;
                        off_in   = '0;
                     end else begin
                        off_in = off_ff + 4'd1;
                     end
                  end
               endcase
            end
            PH_CAPHDR: begin
               unique case (off_ff)
                  4'd0: begin
                     len_in = b;
                     off_in = 4'd1;
                  end
                  4'd1: begin
                     slot_in = b;
                     off_in  = 4'd2;
                  end
                  4'd2: begin
                     acc_in = {24'd0, b};
                     off_in = 4'd3;
                  end
                  default: begin
                     // Classify the capsule; unknown ones restart at the next byte
                     off_in = '0;
                     if (magic == OPER_MAGIC && len_ff == OPER_LEN && slot_ok) begin
                        phase_in = PH_OPER;
                     end else if (magic == STATUS_MAGIC && len_ff == ENC_LEN && slot_ok) begin
                        phase_in = PH_ENC;
                     end else begin
                        phase_in = PH_CAPHDR;
                     end
                  end
               endcase
            end
            PH_OPER: begin
               if (off_ff < 4'd4) begin
                  acc_in = acc_shift;
               end
               if (off_ff == 4'd1) begin
                  pos_in = acc_in[15:0];
               end
               if (off_ff >= 4'd11) begin
                  upd_valid = 1'b1;
                  upd_kind  = KIND_OPER;
                  phase_in  = PH_CAPHDR;
                  off_in    = '0;
               end else begin
                  off_in = off_ff + 4'd1;
               end
            end
            PH_ENC: begin
               acc_in = acc_shift;
               if (off_ff == 4'd1) begin
                  pos_in = acc_in[15:0];
               end
               if (off_ff >= 4'd3) begin
                  upd_valid = 1'b1;
                  upd_kind  = KIND_ENC;
                  phase_in  = PH_CAPHDR;
                  off_in    = '0;
               end else begin
                  off_in = off_ff + 4'd1;
               end
            end
            default: phase_in = PH_DISCARD;
         endcase

         // Close the datagram: report and return to the header
         if (last) begin
            if (err_in == ST_OK && !(phase_in == PH_CAPHDR && off_in == '0)) begin
               sum_status = ST_SHORT;
            end else begin
               sum_status = err_in;
            end
            sum_rsp.kind      = KIND_DONE;
            sum_rsp.status    = sum_status;
            sum_rsp.peer_seq  = seq_in;
            sum_rsp.echo_byte = echo_in;
            sum_rsp.clock_ms  = clk_in;
            sum_rsp.run_end   = 1'b1;
            phase_in = PH_HEADER;
            off_in   = '0;
            err_in   = ST_OK;
            echo_in  = '0;
         end
      end
   end

   // Capsule update beat
   always_comb begin
      upd_rsp          = '0;
      upd_rsp.kind     = upd_kind;
      upd_rsp.slot     = slot_ff[1:0];
      upd_rsp.position = pos_in;
      upd_rsp.aux_word = acc_in[15:0];
      upd_rsp.run_end  = !last;
   end

   // Queue writes: update first, summary after it
   assign push0 = accept && (upd_valid || last);
   assign push1 = accept && upd_valid && last;
   assign res0  = upd_valid ? upd_rsp : sum_rsp;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push0) + RSP_PTR_W'(push1);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      cnt_in    = cnt_ff + RSP_CNT_W'(push0) + RSP_CNT_W'(push1) - RSP_CNT_W'(pop);
   end

   // Hold queue payload
   always_ff @(posedge clock) begin
      if (push0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (push1) begin
         q_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= sum_rsp;
      end
   end

   // Advance parser and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         off_ff    <= '0;
         len_ff    <= '0;
         slot_ff   <= '0;
         acc_ff    <= '0;
         pos_ff    <= '0;
         echo_ff   <= '0;
         err_ff    <= ST_OK;
         seq_ff    <= '0;
         clk_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         off_ff    <= off_in;
         len_ff    <= len_in;
         slot_ff   <= slot_in;
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         echo_ff   <= echo_in;
         err_ff    <= err_in;
         seq_ff    <= seq_in;
         clk_ff    <= clk_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire
